// ===== src/gbsh_pkg.sv =====
`default_nettype none
package gbsh_pkg;

  localparam int TORUS_DIM    = 8;
  localparam int CYCLE_PERIOD = 42;
  localparam int MAX_CALL_LEN = 65536;

  localparam int CNT_W = 17;
  localparam int CYC_W = 6;
  localparam int DVD_W = CNT_W + 16;
  localparam int TK_W  = $clog2(TORUS_DIM + 1);

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] GOLDEN     = 32'h9E3779B9;
  localparam logic [31:0] ROLL_ADD   = 32'h7F4A7C15;
  localparam logic [31:0] SEED_RST   = 32'hA5A5F00D;
  localparam logic [7:0]  GATE_RST   = 8'd160;
  localparam logic [16:0] Q16_ONE    = 17'h10000;
  localparam logic [16:0] Q16_HALF   = 17'h08000;
  localparam logic [16:0] Q16_QUART  = 17'h04000;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CALL_LEN);

  localparam logic [1:0] REG_GATE = 2'd0;
  localparam logic [1:0] REG_SEED = 2'd1;
  localparam logic [1:0] REG_GAIN = 2'd2;
  localparam logic [1:0] REG_CAP  = 2'd3;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_TORUS  = 2'd2;

  function automatic logic [7:0] swap_case(input logic [7:0] raw);
    logic [7:0] low;
    low = raw | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A) return raw ^ 8'h20;
    return raw;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    c = crc ^ {24'd0, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [15:0] torus_word(input logic [31:0] s, input logic [31:0] m);
    logic [31:0] v;
    v = s ^ m;
    return v[31:16] ^ v[15:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c < CNT_MAX) ? c + 1'b1 : c;
  endfunction

endpackage
`default_nettype wire

// ===== src/gbsh_div.sv =====
`default_nettype none
module gbsh_div import gbsh_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [CNT_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  q_r;
  logic [CNT_W:0]    shifted;
  logic              ge;

  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
        dvd_r <= dvd_r << 1;
        q_r   <= {q_r[CNT_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== src/gated_byte_stream_hasher.sv =====
// Gated byte stream hasher.
// Input channel (in_valid/in_ready) takes one byte per transfer; in_end_of_call
// marks the last byte of a call. Results leave on the out_ channel: an emitted
// byte when the byte passes the gate and capacity allows, and on the last byte
// of a call one report followed by TORUS_DIM torus words. out_run_last marks
// the final result caused by an input byte.
// The cfg_ channel writes the four registers; cfg_ready is high only while idle.
// A byte is hashed in S_HASH and gated in S_GATE, then an emitted byte waits in
// S_OBYTE until taken. The last byte of a call adds two serial divisions
// through one shared restoring divider and the coherence, entropy and phi
// products on the shared 17x17 multiplier before the report. A clearing pass
// over the seen-token map starts with the first division, so in_ready returns
// only once that pass is over and all results of the call are taken.
// in_ready is low from the accepted transfer until all its results are taken.
// A stalled receiver holds the current result in the output register and the
// sequencer waits. Synchronous reset loads the threshold, seed, gain and
// capacity defaults, clears the per-call counters and starts the same
// clearing pass, during which in_ready stays low.
`default_nettype none
module gated_byte_stream_hasher import gbsh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_call,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_item_kind,
  output logic [15:0]      out_item_value,
  output logic [16:0]      out_call_bytes_in,
  output logic [16:0]      out_call_bytes_out,
  output logic [16:0]      out_call_bytes_skipped,
  output logic [31:0]      out_crc_value,
  output logic [31:0]      out_rolling_value,
  output logic [16:0]      out_coherence_avg,
  output logic [16:0]      out_entropy_avg,
  output logic [16:0]      out_phi_value,
  output logic [5:0]       out_cycle_count,
  output logic             out_run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HASH    = 4'd1;
  localparam logic [3:0] S_GATE    = 4'd2;
  localparam logic [3:0] S_OBYTE   = 4'd3;
  localparam logic [3:0] S_DT_GO   = 4'd4;
  localparam logic [3:0] S_DT_WAIT = 4'd5;
  localparam logic [3:0] S_DC_GO   = 4'd6;
  localparam logic [3:0] S_DC_WAIT = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_REPORT  = 4'd9;
  localparam logic [3:0] S_TORUS   = 4'd10;

  logic [3:0]  state_r;
  logic        out_valid_r;
  logic [7:0]  gate_r;
  logic [16:0] gain_r;
  logic [16:0] cap_r;
  logic [31:0] rolling_r;
  logic [31:0] crc_r;
  logic [16:0] coh_r;
  logic [16:0] ent_r;
  logic [16:0] phi_r;
  logic [CYC_W-1:0] cyc_r;
  logic        seen_mem [0:255];
  logic        seen_rd_r;
  logic        clr_busy_r;
  logic [7:0]  clr_addr_r;
  logic [8:0]  unique_r;
  logic [CNT_W-1:0] trans_r;
  logic [7:0]  prev_r;
  logic [CNT_W-1:0] in_cnt_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] skip_cnt_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [7:0]  token_r;
  logic [31:0] phi_hash_r;
  logic [16:0] ht_r;
  logic [16:0] cin_r;
  logic [2:0]  step_r;
  logic [17:0] mul_prod_r;
  logic [17:0] acc_r;
  logic [31:0] torus_acc_r;
  logic [TK_W-1:0] tk_r;

  logic [1:0]  kind_r;
  logic [15:0] value_r;
  logic [16:0] rin_r, rout_r, rskip_r, rcoh_r, rent_r, rphi_r;
  logic [31:0] rcrc_r, rroll_r;
  logic [5:0]  rcyc_r;
  logic        rlast_r;

  // Per-byte datapath.
  logic [7:0]  token;
  logic [39:0] hash_prod;
  logic [7:0]  score;
  logic        pass;
  logic [7:0]  gated;
  logic        emit;

  assign token     = swap_case(byte_r);
  assign hash_prod = {32'd0, token} * {8'd0, GOLDEN};
  assign score     = phi_hash_r[7:0] ^ rolling_r[7:0];
  assign pass      = score >= gate_r;
  assign gated     = pass ? ({token_r[6:0], 1'b0} ^ rolling_r[7:0]) : 8'd0;
  assign emit      = pass && (out_cnt_r < cap_r);

  // End-of-call arithmetic.
  logic [16:0] gain_eff, om, omh, h_in, mul_a, mul_b;
  logic [17:0] h_sum;
  logic [33:0] mul_full;
  logic [CYC_W-1:0] cyc_nxt;
  logic [31:0] torus_seed;

  always_comb begin
    if (gain_r == 17'd0) gain_eff = Q16_QUART;
    else if (gain_r > Q16_ONE) gain_eff = Q16_ONE;
    else gain_eff = gain_r;
  end

  assign om    = Q16_ONE - gain_eff;
  assign omh   = ent_r[16] ? 17'd0 : (Q16_ONE - ent_r);
  assign h_sum = {1'b0, unique_r, 8'd0} + {1'b0, ht_r};
  assign h_in  = h_sum[17:1];

  always_comb begin
    unique case (step_r)
      3'd0:    begin mul_a = om;       mul_b = coh_r; end
      3'd1:    begin mul_a = gain_eff; mul_b = cin_r; end
      3'd2:    begin mul_a = om;       mul_b = ent_r; end
      3'd3:    begin mul_a = gain_eff; mul_b = h_in;  end
      default: begin mul_a = omh;      mul_b = coh_r; end
    endcase
  end

  assign mul_full   = {17'd0, mul_a} * {17'd0, mul_b};
  assign cyc_nxt    = (cyc_r == CYC_W'(CYCLE_PERIOD - 1)) ? '0 : cyc_r + 1'b1;
  assign torus_seed = rolling_r ^ {15'd0, phi_r};

  // Shared divider for the two per-call ratios.
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic             div_done;
  logic [CNT_W-1:0] div_q;

  assign div_start    = (state_r == S_DT_GO) || (state_r == S_DC_GO);
  assign div_dividend = (state_r == S_DT_GO) ? {trans_r, 16'd0} : {out_cnt_r, 16'd0};

  gbsh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (in_cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Seen-token map: read while hashing, set at the gate, wiped by the clearing pass.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      seen_mem[clr_addr_r] <= 1'b0;
    end else if (state_r == S_GATE && !seen_rd_r) begin
      seen_mem[token_r] <= 1'b1;
    end
    seen_rd_r <= seen_mem[token];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gate_r      <= GATE_RST;
      gain_r      <= Q16_QUART;
      cap_r       <= Q16_ONE;
      rolling_r   <= SEED_RST;
      crc_r       <= '1;
      coh_r       <= Q16_HALF;
      ent_r       <= Q16_HALF;
      phi_r       <= Q16_QUART;
      cyc_r       <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      unique_r    <= '0;
      trans_r     <= '0;
      prev_r      <= '0;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      skip_cnt_r  <= '0;
      step_r      <= '0;
      tk_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GATE: gate_r <= cfg_data[7:0];
          REG_SEED: begin
            rolling_r <= cfg_data;
            crc_r     <= '1;
            coh_r     <= Q16_HALF;
            ent_r     <= Q16_HALF;
            phi_r     <= Q16_QUART;
            cyc_r     <= '0;
          end
          REG_GAIN: gain_r <= cfg_data[16:0];
          REG_CAP:  cap_r  <= cfg_data[16:0];
          default: ;
        endcase
      end

      // The clearing pass runs beside the end-of-call arithmetic.
      if (state_r == S_DT_GO) begin
        clr_busy_r <= 1'b1;
        clr_addr_r <= '0;
      end else if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == 8'hFF) clr_busy_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            byte_r  <= in_data_byte;
            last_r  <= in_end_of_call;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          token_r    <= token;
          phi_hash_r <= hash_prod[39:8];
          state_r    <= S_GATE;
        end
        S_GATE: begin
          if (!seen_rd_r) unique_r <= unique_r + 1'b1;
          if (in_cnt_r != '0 && token_r != prev_r) trans_r <= sat_inc(trans_r);
          prev_r    <= token_r;
          in_cnt_r  <= sat_inc(in_cnt_r);
          rolling_r <= rotl5(rolling_r ^ (phi_hash_r + ROLL_ADD));
          crc_r     <= crc_byte(crc_r, gated);
          if (emit) begin
            out_cnt_r   <= sat_inc(out_cnt_r);
            kind_r      <= KIND_BYTE;
            value_r     <= {8'd0, gated};
            rin_r       <= '0;
            rout_r      <= '0;
            rskip_r     <= '0;
            rcrc_r      <= '0;
            rroll_r     <= '0;
            rcoh_r      <= '0;
            rent_r      <= '0;
            rphi_r      <= '0;
            rcyc_r      <= '0;
            rlast_r     <= !last_r;
            out_valid_r <= 1'b1;
            state_r     <= S_OBYTE;
          end else begin
            skip_cnt_r <= sat_inc(skip_cnt_r);
            state_r    <= last_r ? S_DT_GO : S_IDLE;
          end
        end
        S_OBYTE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= last_r ? S_DT_GO : S_IDLE;
          end
        end
        S_DT_GO: state_r <= S_DT_WAIT;
        S_DT_WAIT: begin
          if (div_done) begin
            ht_r    <= div_q;
            state_r <= S_DC_GO;
          end
        end
        S_DC_GO: state_r <= S_DC_WAIT;
        S_DC_WAIT: begin
          if (div_done) begin
            cin_r   <= div_q;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // Each product is registered and consumed on the following step.
          mul_prod_r <= mul_full[33:16];
          step_r     <= step_r + 1'b1;
          unique case (step_r)
            3'd1: acc_r <= mul_prod_r;
            3'd2: coh_r <= 17'(acc_r + mul_prod_r);
            3'd3: acc_r <= mul_prod_r;
            3'd4: ent_r <= 17'(acc_r + mul_prod_r);
            3'd6: begin
              phi_r       <= mul_prod_r[16:0];
              cyc_r       <= cyc_nxt;
              torus_acc_r <= 32'(GOLDEN * ({26'd0, cyc_nxt} + 32'd1));
              kind_r      <= KIND_REPORT;
              value_r     <= '0;
              rin_r       <= in_cnt_r;
              rout_r      <= out_cnt_r;
              rskip_r     <= skip_cnt_r;
              rcrc_r      <= ~crc_r;
              rroll_r     <= rolling_r;
              rcoh_r      <= coh_r;
              rent_r      <= ent_r;
              rphi_r      <= mul_prod_r[16:0];
              rcyc_r      <= cyc_nxt;
              rlast_r     <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= S_REPORT;
            end
            default: ;
          endcase
        end
        S_REPORT, S_TORUS: begin
          if (out_ready) begin
            if (state_r == S_TORUS && tk_r == TK_W'(TORUS_DIM)) begin
              out_valid_r <= 1'b0;
              unique_r    <= '0;
              trans_r     <= '0;
              prev_r      <= '0;
              in_cnt_r    <= '0;
              out_cnt_r   <= '0;
              skip_cnt_r  <= '0;
              state_r     <= S_IDLE;
            end else begin
              kind_r      <= KIND_TORUS;
              value_r     <= torus_word(torus_seed, torus_acc_r);
              rin_r       <= '0;
              rout_r      <= '0;
              rskip_r     <= '0;
              rcrc_r      <= '0;
              rroll_r     <= '0;
              rcoh_r      <= '0;
              rent_r      <= '0;
              rphi_r      <= '0;
              rcyc_r      <= '0;
              torus_acc_r <= torus_acc_r + GOLDEN;
              if (state_r == S_REPORT) begin
                tk_r    <= TK_W'(1);
                rlast_r <= (TORUS_DIM == 1);
              end else begin
                tk_r    <= tk_r + 1'b1;
                rlast_r <= (tk_r == TK_W'(TORUS_DIM - 1));
              end
              state_r <= S_TORUS;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready               = (state_r == S_IDLE) && !clr_busy_r;
  assign cfg_ready              = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_item_kind          = kind_r;
  assign out_item_value         = value_r;
  assign out_call_bytes_in      = rin_r;
  assign out_call_bytes_out     = rout_r;
  assign out_call_bytes_skipped = rskip_r;
  assign out_crc_value          = rcrc_r;
  assign out_rolling_value      = rroll_r;
  assign out_coherence_avg      = rcoh_r;
  assign out_entropy_avg        = rent_r;
  assign out_phi_value          = rphi_r;
  assign out_cycle_count        = rcyc_r;
  assign out_run_last           = rlast_r;

endmodule
`default_nettype wire

// ===== src/gbsh_checker.sv =====
`default_nettype none
module gbsh_checker import gbsh_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_item_kind,
  input wire logic [15:0] out_item_value,
  input wire logic [31:0] out_crc_value,
  input wire logic [5:0]  out_cycle_count,
  input wire logic        out_run_last
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_value))
    else $error("result changed while stalled");

  // The block works on one byte at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // Torus words always follow a report.
  a_report_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_REPORT |-> !out_run_last)
    else $error("report marked as final result");

  a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind != KIND_REPORT |-> out_crc_value == 32'd0 &&
      out_cycle_count == 6'd0)
    else $error("report fields set outside a report");

  a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_REPORT && in_valid |->
      out_cycle_count < 6'(CYCLE_PERIOD))
    else $error("cycle count out of range");

endmodule

bind gated_byte_stream_hasher gbsh_checker u_gbsh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_item_kind   (out_item_kind),
  .out_item_value  (out_item_value),
  .out_crc_value   (out_crc_value),
  .out_cycle_count (out_cycle_count),
  .out_run_last    (out_run_last)
);
`default_nettype wire
